@@ src/lsd_pkg.sv @@
// ----------------------------------------------------------------------------
// lsd_pkg
// Types and constants shared by the line sensor hysteresis/debounce block.
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam int LANES         = 4;
  localparam int SAMPLE_BITS   = 10;
  localparam int MARGIN_BITS   = 9;
  localparam int DEBOUNCE_BITS = 8;
  localparam int SUM_BITS      = SAMPLE_BITS + 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = SAMPLE_BITS;

  // register map
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH0  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MARGIN   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERT   = 3'd6;

  localparam logic [SAMPLE_BITS-1:0]   THRESH_RESET   = 10'd512;
  localparam logic [MARGIN_BITS-1:0]   MARGIN_RESET   = 9'd20;
  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 8'd3;
  localparam logic [LANES-1:0]         INVERT_RESET   = 4'd0;

  typedef logic [SAMPLE_BITS-1:0]   sample_t;
  typedef logic [MARGIN_BITS-1:0]   margin_t;
  typedef logic [DEBOUNCE_BITS-1:0] debounce_t;

  typedef struct packed {
    sample_t sample_lane0;
    sample_t sample_lane1;
    sample_t sample_lane2;
    sample_t sample_lane3;
  } sweep_t;

  typedef struct packed {
    logic [LANES-1:0] stable_bits;
    logic [LANES-1:0] threshold_bits;
    logic [LANES-1:0] hysteresis_bits;
  } result_t;

  typedef struct packed {
    logic stable;
    logic thresh;
    logic hyst;
  } lane_flags_t;

endpackage

@@ src/lsd_lane.sv @@
// ----------------------------------------------------------------------------
// lsd_lane
// One sensor lane: threshold compare, hysteresis band and debounce counter.
// ----------------------------------------------------------------------------
module lsd_lane #(
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  lsd_pkg::sample_t      sample,
  input  lsd_pkg::sample_t      thresh,
  input  lsd_pkg::margin_t      margin,
  input  lsd_pkg::debounce_t    debounce_reads,
  input  logic                  invert,
  output lsd_pkg::lane_flags_t  flags
);
  import lsd_pkg::*;

  localparam int CMP_BITS = (COUNT_BITS > DEBOUNCE_BITS) ? COUNT_BITS : DEBOUNCE_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic                  hyst_mem;
  logic                  committed;
  logic                  candidate;
  logic [COUNT_BITS-1:0] count;

  logic                  hyst_mem_next;
  logic                  committed_next;
  logic                  candidate_next;
  logic [COUNT_BITS-1:0] count_next;

  logic [SUM_BITS-1:0]   s_wide;
  logic [SUM_BITS-1:0]   t_wide;
  logic [SUM_BITS-1:0]   m_wide;
  logic                  det;
  logic                  set_hit;
  logic                  clr_hit;
  logic                  hb;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  commit;

  assign s_wide = SUM_BITS'(sample);
  assign t_wide = SUM_BITS'(thresh);
  assign m_wide = SUM_BITS'(margin);

  assign det     = (sample >= thresh);
  assign set_hit = (s_wide >= t_wide + m_wide);
  // s < t - m, rearranged to stay unsigned
  assign clr_hit = (s_wide + m_wide < t_wide);

  assign hyst_mem_next = set_hit ? 1'b1 : (clr_hit ? 1'b0 : hyst_mem);
  assign hb            = hyst_mem_next ^ invert;

  assign count_inc = (count != COUNT_MAX) ? count + 1'b1 : count;
  assign commit    = (CMP_BITS'(count_inc) >= CMP_BITS'(debounce_reads)) ||
                     (count_inc == COUNT_MAX);

  always_comb begin
    committed_next = committed;
    candidate_next = candidate;
    count_next     = count;
    priority if (hb == committed) begin
      candidate_next = committed;
      count_next     = '0;
    end else if (hb == candidate) begin
      if (commit) begin
        committed_next = candidate;
        count_next     = '0;
      end else begin
        count_next = count_inc;
      end
    end else begin
      candidate_next = hb;
      count_next     = COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hyst_mem  <= 1'b0;
      committed <= 1'b0;
      candidate <= 1'b0;
      count     <= '0;
    end else if (fire) begin
      hyst_mem  <= hyst_mem_next;
      committed <= committed_next;
      candidate <= candidate_next;
      count     <= count_next;
    end
  end

  assign flags.stable = committed_next;
  assign flags.thresh = det ^ invert;
  assign flags.hyst   = hb;

endmodule

@@ src/lsd_merge.sv @@
// ----------------------------------------------------------------------------
// lsd_merge
// Gathers lane flags into one result beat; output register plus skid stage.
// ----------------------------------------------------------------------------
module lsd_merge (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      fire,
  input  lsd_pkg::lane_flags_t [lsd_pkg::LANES-1:0] flags,
  output logic                                      busy,
  output logic                                      result_valid,
  input  logic                                      result_stall,
  output lsd_pkg::result_t                          result
);
  import lsd_pkg::*;

  result_t merged;
  result_t out_data;
  result_t skid_data;
  logic    out_valid;
  logic    skid_valid;
  logic    out_free;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      merged.stable_bits[i]     = flags[i].stable;
      merged.threshold_bits[i]  = flags[i].thresh;
      merged.hysteresis_bits[i] = flags[i].hyst;
    end
  end

  assign out_free = !out_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || fire;
      skid_valid <= 1'b0;
    end else if (fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : merged;
    end
    if (!out_free && fire) begin
      skid_data <= merged;
    end
  end

  assign busy         = skid_valid;
  assign result_valid = out_valid;
  assign result       = out_data;

endmodule

@@ src/line_sensor_hysteresis_debounce.sv @@
// ----------------------------------------------------------------------------
// line_sensor_hysteresis_debounce
// Four-lane line sensor filter: threshold, hysteresis and debounced bits.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: one beat is one sweep of four 10-bit samples; it is taken
//   at a clock edge with sample_valid high and sample_stall low.
//   result channel: one beat per sweep carrying stable, threshold and
//   hysteresis bits per lane; taken when result_valid is high and
//   result_stall is low.
//   cfg port: cfg_write with cfg_index/cfg_data writes a register at once;
//   write only while the block holds no pending beats.
// Result: each sweep's flags are registered, into the skid entry if stalled.
// Throughput: one sweep per cycle while sample_stall is low; every lane has
//   its own compare and debounce counter, so the lanes run in parallel.
// Stall: the result register plus one skid entry absorb a stalled receiver;
//   sample_stall rises once the skid entry is full and drops once drained.
// Reset: clears all lane state and loads the register defaults
//   (threshold 512, margin 20, three reads, no inversion).
// ----------------------------------------------------------------------------
module line_sensor_hysteresis_debounce #(
  parameter int COUNT_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  lsd_pkg::sweep_t                     sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output lsd_pkg::result_t                    result,
  input  logic                                cfg_write,
  input  logic [lsd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [lsd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import lsd_pkg::*;

  sample_t     thresh [LANES];
  margin_t     margin;
  debounce_t   debounce_reads;
  logic [LANES-1:0] invert_mask;

  sample_t     samples [LANES];
  lane_flags_t [LANES-1:0] flags;
  logic        fire;
  logic        busy;

  assign fire         = sample_valid && !sample_stall;
  assign sample_stall = busy;

  assign samples[0] = sample.sample_lane0;
  assign samples[1] = sample.sample_lane1;
  assign samples[2] = sample.sample_lane2;
  assign samples[3] = sample.sample_lane3;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        thresh[i] <= THRESH_RESET;
      end
      margin         <= MARGIN_RESET;
      debounce_reads <= DEBOUNCE_RESET;
      invert_mask    <= INVERT_RESET;
    end else if (cfg_write) begin
      for (int i = 0; i < LANES; i++) begin
        if (cfg_index == REG_THRESH0 + CFG_IDX_BITS'(i)) begin
          thresh[i] <= cfg_data[SAMPLE_BITS-1:0];
        end
      end
      if (cfg_index == REG_MARGIN) begin
        margin <= cfg_data[MARGIN_BITS-1:0];
      end
      if (cfg_index == REG_DEBOUNCE) begin
        debounce_reads <= cfg_data[DEBOUNCE_BITS-1:0];
      end
      if (cfg_index == REG_INVERT) begin
        invert_mask <= cfg_data[LANES-1:0];
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lsd_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk            (clk),
      .rst            (rst),
      .fire           (fire),
      .sample         (samples[g]),
      .thresh         (thresh[g]),
      .margin         (margin),
      .debounce_reads (debounce_reads),
      .invert         (invert_mask[g]),
      .flags          (flags[g])
    );
  end

  lsd_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .flags        (flags),
    .busy         (busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // skid entry only fills behind a held result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid)
    else $error("sample_stall without a pending result beat");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_valid)
    else $error("accepted sweep produced no result beat");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_stall) |-> $past(result_valid && result_stall && fire))
    else $error("sample_stall rose without a stalled result and a new sweep");

endmodule
